/* hw/rtl/sle_pkg.sv */
// sle_pkg: shared types, codes and constants of the sorted list engine
package sle_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_OUT_W  = 6;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    SLE_IDLE,
    SLE_CMP,
    SLE_APPLY
  } sle_state_t;

  typedef struct packed {
    logic in_ready;
    logic cmp_en;
    logic apply_go;
  } sle_ctrl_t;

  typedef struct packed {
    logic                    cmp_en;
    logic                    ins_en;
    logic                    rem_en;
    logic signed [VAL_W-1:0] key;
  } sle_op_t;

  typedef struct packed {
    logic                    lt;
    logic signed [VAL_W-1:0] value;
  } sle_link_t;

endpackage

/* hw/rtl/sle_if.sv */
// sle_if: request and result channel interfaces of the sorted list engine
interface sle_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [sle_pkg::CMD_W-1:0]             command;
  logic signed [sle_pkg::VAL_W-1:0]      value;

  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

interface sle_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [sle_pkg::STATUS_W-1:0]          status;
  logic                                  has_previous;
  logic signed [sle_pkg::VAL_W-1:0]      previous_value;
  logic [sle_pkg::COUNT_OUT_W-1:0]       entry_count;

  modport source (output valid, status, has_previous, previous_value, entry_count,
                  input ready);
  modport sink (input valid, status, has_previous, previous_value, entry_count,
                output ready);
endinterface

/* hw/rtl/sle_cell.sv */
// sle_cell: one storage cell of the sorted row, compares and shifts with its neighbours
module sle_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sle_pkg::sle_op_t    op,
  input  logic [CntW-1:0]     count,
  input  sle_pkg::sle_link_t  left_in,
  input  sle_pkg::sle_link_t  right_in,
  output sle_pkg::sle_link_t  link_out,
  output logic                hit,
  output logic                pred
);

  logic                             occupied;
  logic                             at_pos;
  logic                             lt_r, lt_nxt;
  logic                             eq_r, eq_nxt;
  logic signed [sle_pkg::VAL_W-1:0] value_r, value_nxt;

  assign occupied = CntW'(Idx) < count;
  assign at_pos   = !lt_r && left_in.lt;

  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (op.cmp_en) begin
      lt_nxt = occupied && (value_r < op.key);
      eq_nxt = occupied && (value_r == op.key);
    end
  end

  always_comb begin
    value_nxt = value_r;
    if (op.ins_en) begin
      if (at_pos) begin
        value_nxt = op.key;
      end else if (!lt_r) begin
        value_nxt = left_in.value;
      end
    end else if (op.rem_en && !lt_r) begin
      value_nxt = right_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link_out.lt    = lt_r;
  assign link_out.value = value_r;
  assign hit            = at_pos && eq_r;
  assign pred           = lt_r && !right_in.lt;

endmodule

/* hw/rtl/sle_ctrl.sv */
// sle_ctrl: request sequencer, accept then compare then apply
module sle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_free,
  output sle_pkg::sle_ctrl_t  ctrl
);

  sle_pkg::sle_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sle_pkg::SLE_IDLE:  if (in_valid) state_nxt = sle_pkg::SLE_CMP;
      sle_pkg::SLE_CMP:   state_nxt = sle_pkg::SLE_APPLY;
      sle_pkg::SLE_APPLY: if (out_free) state_nxt = sle_pkg::SLE_IDLE;
      default:            state_nxt = sle_pkg::SLE_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      sle_pkg::SLE_IDLE:  ctrl.in_ready = 1'b1;
      sle_pkg::SLE_CMP:   ctrl.cmp_en   = 1'b1;
      sle_pkg::SLE_APPLY: ctrl.apply_go = out_free;
      default:            ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sle_pkg::SLE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/sorted_list_engine.sv */
// sorted_list_engine: sorted store of signed keys built as a row of compare-and-shift cells
//
// in_ch carries requests (command, value); out_ch returns one result per request:
// status, has_previous, previous_value and entry_count after the request.
// Commands: insert keeps ascending order and goes ahead of equal keys, remove
// deletes one matching key, search reports the predecessor of the first match.
// A request is accepted in IDLE, all cells compare their stored key with it in
// CMP, and the row shifts and the result register loads in APPLY. The result
// becomes valid at the same edge at which in_ch.ready returns, so the block
// takes no new request until the last one has been applied. The result
// register lets the next request be accepted and compared while a result
// waits; if out_ch stalls, the update of that request is held until the
// waiting result is taken.
// Reset (rst_n low, synchronous) empties the store and drops any pending
// result; stored keys need no clearing as only occupied cells are read.
module sorted_list_engine #(
  parameter int unsigned Capacity = sle_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sle_in_if.sink    in_ch,
  sle_out_if.source out_ch
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  sle_pkg::sle_ctrl_t               ctrl;
  sle_pkg::sle_op_t                 op;
  sle_pkg::sle_link_t               cell_link [Capacity];
  logic [Capacity-1:0]              cell_hit;
  logic [Capacity-1:0]              cell_pred;

  logic [sle_pkg::CMD_W-1:0]        cmd_r, cmd_nxt;
  logic signed [sle_pkg::VAL_W-1:0] key_r, key_nxt;
  logic [CntW-1:0]                  count_r, count_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [sle_pkg::STATUS_W-1:0]     status_r, status_nxt;
  logic                             has_prev_r, has_prev_nxt;
  logic signed [sle_pkg::VAL_W-1:0] prev_r, prev_nxt;

  logic                             out_free;
  logic                             full;
  logic                             found;
  logic                             pred_any;
  logic signed [sle_pkg::VAL_W-1:0] pred_value;

  assign out_free = !out_valid_r || out_ch.ready;
  assign full     = count_r == CntW'(Capacity);

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign in_ch.ready = ctrl.in_ready;

  always_comb begin
    found      = 1'b0;
    pred_any   = 1'b0;
    pred_value = '0;
    for (int i = 0; i < Capacity; i++) begin
      found    = found | cell_hit[i];
      pred_any = pred_any | cell_pred[i];
      if (cell_pred[i]) begin
        pred_value = pred_value | cell_link[i].value;
      end
    end
  end

  assign op.cmp_en = ctrl.cmp_en;
  assign op.ins_en = ctrl.apply_go && (cmd_r == sle_pkg::CMD_INSERT) && !full;
  assign op.rem_en = ctrl.apply_go && (cmd_r == sle_pkg::CMD_REMOVE) && found;
  assign op.key    = key_r;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    sle_pkg::sle_link_t left_link;
    sle_pkg::sle_link_t right_link;

    if (g == 0) begin : g_first
      assign left_link = '{lt: 1'b1, value: '0};
    end else begin : g_mid_l
      assign left_link = cell_link[g-1];
    end

    if (g == Capacity - 1) begin : g_last
      assign right_link = '{lt: 1'b0, value: '0};
    end else begin : g_mid_r
      assign right_link = cell_link[g+1];
    end

    sle_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (op),
      .count    (count_r),
      .left_in  (left_link),
      .right_in (right_link),
      .link_out (cell_link[g]),
      .hit      (cell_hit[g]),
      .pred     (cell_pred[g])
    );
  end

  // request capture
  always_comb begin
    cmd_nxt = cmd_r;
    key_nxt = key_r;
    if (in_ch.valid && ctrl.in_ready) begin
      cmd_nxt = in_ch.command;
      key_nxt = in_ch.value;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (op.ins_en) begin
      count_nxt = count_r + CntW'(1);
    end else if (op.rem_en) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  // result
  always_comb begin
    status_nxt   = sle_pkg::ST_OK;
    has_prev_nxt = 1'b0;
    prev_nxt     = '0;
    case (cmd_r)
      sle_pkg::CMD_INSERT: begin
        if (full) status_nxt = sle_pkg::ST_FULL;
      end
      sle_pkg::CMD_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = sle_pkg::ST_EMPTY;
        end else if (!found) begin
          status_nxt = sle_pkg::ST_NOT_FOUND;
        end
      end
      sle_pkg::CMD_SEARCH: begin
        if (count_r == '0) begin
          status_nxt = sle_pkg::ST_EMPTY;
        end else if (!found) begin
          status_nxt = sle_pkg::ST_NOT_FOUND;
        end else if (pred_any) begin
          has_prev_nxt = 1'b1;
          prev_nxt     = pred_value;
        end
      end
      default: status_nxt = sle_pkg::ST_OK;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.apply_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    if (ctrl.apply_go) begin
      status_r   <= status_nxt;
      has_prev_r <= has_prev_nxt;
      prev_r     <= prev_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.has_previous   = has_prev_r;
  assign out_ch.previous_value = prev_r;
  assign out_ch.entry_count    = sle_pkg::COUNT_OUT_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Capacity))
    else $error("stored count beyond capacity");

  a_count_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(ctrl.apply_go) |-> $stable(count_r))
    else $error("stored count changed outside an update");

  a_full_means_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == sle_pkg::ST_FULL) |-> full)
    else $error("full reported below capacity");

  a_one_hit_at_most: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_hit))
    else $error("more than one cell claims the match");

endmodule

/* test/tb_top.sv */
// tb_top: self-checking testbench of the sorted list engine against a shadow sorted store
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int unsigned CAPACITY = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1925;
  localparam int CYCLE_LIMIT = 400000;
  localparam int STALL_CYCLES = 400;
  localparam int PRINT_CAP = 50;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    IDLE_RECEIVER_HEAVY,
    IDLE_SENDER_HEAVY,
    IDLE_OFF
  } idle_mode_t;

  typedef enum logic [1:0] {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_kind_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic                    has_previous;
    logic signed [VAL_W-1:0] previous_value;
    logic [COUNT_OUT_W-1:0]  entry_count;
  } list_reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
    logic                    typed;
    list_reply_t             reply;
  } directed_row_t;

  localparam int DIRECTED_COUNT = 25;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{CMD_REMOVE, 32'sd5, 1'b1, '{ST_EMPTY, 1'b0, 32'sd0, 6'd0}},
    '{CMD_SEARCH, 32'sd5, 1'b1, '{ST_EMPTY, 1'b0, 32'sd0, 6'd0}},
    '{CMD_UNUSED, 32'sd7, 1'b1, '{ST_OK, 1'b0, 32'sd0, 6'd0}},
    '{CMD_INSERT, KEY_MIN, 1'b1, '{ST_OK, 1'b0, 32'sd0, 6'd1}},
    '{CMD_INSERT, KEY_MAX, 1'b1, '{ST_OK, 1'b0, 32'sd0, 6'd2}},
    '{CMD_SEARCH, KEY_MAX, 1'b1, '{ST_OK, 1'b1, KEY_MIN, 6'd2}},
    '{CMD_SEARCH, KEY_MIN, 1'b1, '{ST_OK, 1'b0, 32'sd0, 6'd2}},
    '{CMD_SEARCH, 32'sd0, 1'b1, '{ST_NOT_FOUND, 1'b0, 32'sd0, 6'd2}},
    '{CMD_REMOVE, 32'sd0, 1'b1, '{ST_NOT_FOUND, 1'b0, 32'sd0, 6'd2}},
    '{CMD_INSERT, 32'sd0, 1'b0, '0},
    '{CMD_INSERT, 32'sd0, 1'b0, '0},
    '{CMD_SEARCH, 32'sd0, 1'b0, '0},
    '{CMD_INSERT, -32'sd1, 1'b0, '0},
    '{CMD_SEARCH, 32'sd0, 1'b0, '0},
    '{CMD_UNUSED, KEY_MAX, 1'b0, '0},
    '{CMD_REMOVE, 32'sd0, 1'b0, '0},
    '{CMD_SEARCH, 32'sd0, 1'b0, '0},
    '{CMD_REMOVE, KEY_MIN, 1'b0, '0},
    '{CMD_REMOVE, KEY_MAX, 1'b0, '0},
    '{CMD_REMOVE, 32'sd0, 1'b0, '0},
    '{CMD_REMOVE, -32'sd1, 1'b0, '0},
    '{CMD_INSERT, 32'sd42, 1'b0, '0},
    '{CMD_REMOVE, 32'sd41, 1'b1, '{ST_NOT_FOUND, 1'b0, 32'sd0, 6'd1}},
    '{CMD_REMOVE, 32'sd42, 1'b1, '{ST_OK, 1'b0, 32'sd0, 6'd0}},
    '{CMD_INSERT, 32'sh5555_5555, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  sle_in_if in_ch ();
  sle_out_if out_ch ();

  sorted_list_engine #(
    .Capacity(CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [VAL_W-1:0] shadow_keys [CAPACITY];
  int unsigned shadow_count = 0;
  list_reply_t replies_due [$];
  idle_mode_t idle_mode = IDLE_RECEIVER_HEAVY;
  int fault_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  function automatic list_reply_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                     input logic signed [VAL_W-1:0] key);
    list_reply_t r;
    int unsigned pos;
    int unsigned k;
    r = '0;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < key) pos++;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (k = shadow_count; k > pos; k--) shadow_keys[k] = shadow_keys[k-1];
          shadow_keys[pos] = key;
          shadow_count++;
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= shadow_count || shadow_keys[pos] != key) begin
          r.status = ST_NOT_FOUND;
        end else if (cmd == CMD_REMOVE) begin
          for (k = pos; k + 1 < shadow_count; k++) shadow_keys[k] = shadow_keys[k+1];
          shadow_count--;
        end else if (pos > 0) begin
          r.has_previous = 1'b1;
          r.previous_value = shadow_keys[pos-1];
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_count[COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report(input string msg);
    if (fault_count < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
    fault_count++;
  endtask

  task automatic compare_reply();
    list_reply_t want;
    if (replies_due.size() == 0) begin
      report($sformatf("result with no request waiting, status %0d", out_ch.status));
    end else begin
      want = replies_due.pop_front();
      if (out_ch.status !== want.status)
        report($sformatf("status got %0d expected %0d", out_ch.status, want.status));
      if (out_ch.has_previous !== want.has_previous)
        report($sformatf("has_previous got %0b expected %0b",
                         out_ch.has_previous, want.has_previous));
      if (out_ch.previous_value !== want.previous_value)
        report($sformatf("previous_value got %0d expected %0d",
                         out_ch.previous_value, want.previous_value));
      if (out_ch.entry_count !== want.entry_count)
        report($sformatf("entry_count got %0d expected %0d",
                         out_ch.entry_count, want.entry_count));
    end
  endtask

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] key);
    while ($urandom_range(99) < (idle_mode == IDLE_RECEIVER_HEAVY ? 8 :
                                 idle_mode == IDLE_SENDER_HEAVY ? 67 : 0)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value <= key;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // result side: random stalls, one long hold once idling is switched off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1) begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) compare_reply();
        if (idle_mode == IDLE_OFF && !stall_done) begin
          stall_left = STALL_CYCLES;
          stall_done = 1'b1;
        end
        if (stall_left != 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(99) >= (idle_mode == IDLE_RECEIVER_HEAVY ? 67 :
                                                  idle_mode == IDLE_SENDER_HEAVY ? 8 : 0));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int row;
    int real_items;
    int burst_left;
    int roll;
    int small_key;
    burst_kind_t burst;
    logic [CMD_W-1:0] cmd;
    logic signed [VAL_W-1:0] key;
    list_reply_t predicted;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_INSERT;
    in_ch.value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < DIRECTED_COUNT; row++) begin
      send_request(DIRECTED_ROWS[row].command, DIRECTED_ROWS[row].value);
      predicted = apply_list_command(DIRECTED_ROWS[row].command, DIRECTED_ROWS[row].value);
      replies_due.push_back(DIRECTED_ROWS[row].typed ? DIRECTED_ROWS[row].reply : predicted);
    end

    real_items = 0;
    burst_left = 0;
    burst = BURST_FILL;
    while (real_items < RANDOM_ITEMS) begin
      if (real_items >= 2 * RANDOM_ITEMS / 3) idle_mode <= IDLE_OFF;
      else if (real_items >= RANDOM_ITEMS / 3) idle_mode <= IDLE_SENDER_HEAVY;
      if (burst_left == 0) begin
        burst = burst_kind_t'($urandom_range(2));
        burst_left = $urandom_range(30, 70);
      end
      burst_left--;
      roll = $urandom_range(99);
      case (burst)
        BURST_FILL:
          cmd = roll < 75 ? CMD_INSERT : roll < 90 ? CMD_SEARCH : roll < 97 ? CMD_REMOVE
                                                                            : CMD_UNUSED;
        BURST_DRAIN:
          cmd = roll < 70 ? CMD_REMOVE : roll < 90 ? CMD_SEARCH : roll < 97 ? CMD_INSERT
                                                                            : CMD_UNUSED;
        default:
          cmd = roll < 35 ? CMD_INSERT : roll < 65 ? CMD_REMOVE : roll < 95 ? CMD_SEARCH
                                                                            : CMD_UNUSED;
      endcase
      if ((cmd == CMD_REMOVE || cmd == CMD_SEARCH) && shadow_count != 0 &&
          $urandom_range(99) < 80) begin
        key = shadow_keys[$urandom_range(shadow_count - 1)];
      end else begin
        roll = $urandom_range(99);
        small_key = $urandom_range(16);
        if (roll < 10) begin
          case ($urandom_range(3))
            0: key = KEY_MIN;
            1: key = KEY_MAX;
            2: key = 32'sd0;
            default: key = -32'sd1;
          endcase
        end else if (roll < 55) begin
          key = small_key - 8;
        end else begin
          key = $urandom;
        end
      end
      send_request(cmd, key);
      predicted = apply_list_command(cmd, key);
      replies_due.push_back(predicted);
      if (cmd != CMD_UNUSED) real_items++;
    end
    in_ch.valid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
